@@ src/crtc_pkg.sv @@
package crtc_pkg;

   localparam int MAX_FUNCS = 64;
   localparam int IDX_W = $clog2(MAX_FUNCS);
   localparam int CNT_W = $clog2(MAX_FUNCS + 1);

   localparam logic [6:0] OPC_MASK = 7'h7f;
   localparam logic [4:0] REG_MASK = 5'h1f;
   localparam logic [6:0] OPC_JAL = 7'h6F;
   localparam logic [6:0] OPC_JALR = 7'h67;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_CALL = 3'd1;
   localparam logic [2:0] EV_RET = 3'd2;
   localparam logic [2:0] EV_JUMP = 3'd3;
   localparam logic [2:0] EV_MISS = 3'd4;

   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_CALL = 2'd1;
   localparam logic [1:0] CLS_RET = 2'd2;
   localparam logic [1:0] CLS_JUMP = 2'd3;

   // One classified transaction as it waits between front and back.
   typedef struct packed {
      logic        mode;
      logic [31:0] entry_start;
      logic [31:0] entry_size;
      logic [31:0] prev_pc;
      logic [31:0] next_pc;
      logic [1:0]  cls;
   } work_type;

endpackage

@@ src/crtc_front.sv @@
module crtc_front
   import crtc_pkg::*;
(
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [31:0] req_entry_start,
   input  logic [31:0] req_entry_size,
   input  logic [31:0] req_prev_pc,
   input  logic [31:0] req_next_pc,
   input  logic [31:0] req_instruction,
   input  logic        q_full,
   output logic        q_push,
   output work_type    q_data
);

   logic [6:0] opc;
   logic [4:0] rd;
   logic [4:0] rs1;
   logic [11:0] imm;

   assign busy = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      opc = req_instruction[6:0] & OPC_MASK;
      rd = req_instruction[11:7] & REG_MASK;
      rs1 = req_instruction[19:15] & REG_MASK;
      imm = req_instruction[31:20];
      q_data.mode = req_mode;
      q_data.entry_start = req_entry_start;
      q_data.entry_size = req_entry_size;
      q_data.prev_pc = req_prev_pc;
      q_data.next_pc = req_next_pc;
      q_data.cls = CLS_NONE;
      if (opc == OPC_JAL || opc == OPC_JALR) begin
         if (rd != 5'd0) begin
            q_data.cls = CLS_CALL;
         end else if (opc == OPC_JALR && rs1 == 5'd1 && imm == 12'd0) begin
            q_data.cls = CLS_RET;
         end else begin
            q_data.cls = CLS_JUMP;
         end
      end
   end

endmodule

@@ src/crtc_queue.sv @@
module crtc_queue
   import crtc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output work_type pop_data
);

   work_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/crtc_back.sv @@
module crtc_back
   import crtc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  work_type          q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic [2:0]        rsp_event_kind,
   output logic              rsp_from_found,
   output logic [5:0]        rsp_from_index,
   output logic              rsp_to_found,
   output logic [5:0]        rsp_to_index,
   output logic signed [15:0] rsp_depth,
   output logic              rsp_table_full
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [31:0] start_mem [MAX_FUNCS];
   logic [31:0] size_mem [MAX_FUNCS];
   logic [31:0] rd_start_ff;
   logic [31:0] rd_size_ff;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic signed [15:0] depth_ff, depth_in;
   work_type         cur_ff, cur_in;
   logic             ff_ff, ff_in, tf_ff, tf_in;
   logic [IDX_W-1:0] fi_ff, fi_in, ti_ff, ti_in;
   logic             v_ff, v_in;
   logic [2:0]       k_ff, k_in;
   logic             full_ff, full_in;
   logic             load_wr;
   logic [31:0]      hi;
   logic             differ;
   logic [2:0]       kind;

   assign q_pop = (state_ff == ST_IDLE) && q_not_empty;
   assign load_wr = q_pop && !q_data.mode && (count_ff != CNT_W'(MAX_FUNCS));

   // Entries are read one a cycle; the read data is registered and arrives in the cycle after the read.
   always_ff @(posedge clock) begin
      if (load_wr) begin
         start_mem[count_ff[IDX_W-1:0]] <= q_data.entry_start;
         size_mem[count_ff[IDX_W-1:0]] <= q_data.entry_size;
      end
      rd_start_ff <= start_mem[scan_ff[IDX_W-1:0]];
      rd_size_ff <= size_mem[scan_ff[IDX_W-1:0]];
      rd_idx_ff <= scan_ff[IDX_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      rd_valid_in = 1'b0;
      depth_in = depth_ff;
      cur_in = cur_ff;
      ff_in = ff_ff;
      tf_in = tf_ff;
      fi_in = fi_ff;
      ti_in = ti_ff;
      v_in = 1'b0;
      k_in = k_ff;
      full_in = full_ff;
      hi = rd_start_ff + rd_size_ff;
      differ = (ff_ff != tf_ff) || (ff_ff && tf_ff && fi_ff != ti_ff);
      kind = EV_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in = q_data;
               ff_in = 1'b0;
               tf_in = 1'b0;
               fi_in = '0;
               ti_in = '0;
               if (!q_data.mode) begin
                  v_in = 1'b1;
                  k_in = EV_NONE;
                  full_in = (count_ff == CNT_W'(MAX_FUNCS));
                  if (!full_in) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  scan_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff != count_ff) begin
               rd_valid_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               if (cur_ff.prev_pc >= rd_start_ff && cur_ff.prev_pc < hi) begin
                  ff_in = 1'b1;
                  fi_in = rd_idx_ff;
               end
               if (cur_ff.next_pc >= rd_start_ff && cur_ff.next_pc < hi) begin
                  tf_in = 1'b1;
                  ti_in = rd_idx_ff;
               end
            end
            if (scan_ff == count_ff && !rd_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            case (cur_ff.cls)
               CLS_CALL: kind = EV_CALL;
               CLS_RET:  kind = EV_RET;
               CLS_JUMP: kind = differ ? EV_JUMP : EV_NONE;
               default:  kind = EV_NONE;
            endcase
            if (kind != EV_NONE && !(ff_ff && tf_ff)) begin
               kind = EV_MISS;
            end else if (kind == EV_CALL && depth_ff != 16'sh7fff) begin
               depth_in = depth_ff + 16'sd1;
            end else if (kind == EV_RET && depth_ff != -16'sh8000) begin
               depth_in = depth_ff - 16'sd1;
            end
            k_in = kind;
            full_in = 1'b0;
            v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         scan_ff <= '0;
         rd_valid_ff <= 1'b0;
         depth_ff <= '0;
         v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff <= scan_in;
         rd_valid_ff <= rd_valid_in;
         depth_ff <= depth_in;
         v_ff <= v_in;
      end
      cur_ff <= cur_in;
      ff_ff <= ff_in;
      tf_ff <= tf_in;
      fi_ff <= fi_in;
      ti_ff <= ti_in;
      k_ff <= k_in;
      full_ff <= full_in;
   end

   assign rsp_valid = v_ff;
   assign rsp_event_kind = k_ff;
   assign rsp_from_found = ff_ff;
   assign rsp_from_index = 6'(fi_ff);
   assign rsp_to_found = tf_ff;
   assign rsp_to_index = 6'(ti_ff);
   assign rsp_depth = depth_ff;
   assign rsp_table_full = full_ff;

endmodule

@@ src/call_return_trace_classifier_top.sv @@
// Channel   | Ports                                    | Handshake
// request   | req_mode .. req_instruction              | start high, busy low
// response  | rsp_event_kind .. rsp_table_full         | rsp_valid, one cycle
// A load transaction passes through the queue and is answered by a registered
// response once the back end pops it. A trace transaction scans the table one
// entry a cycle through the single read port of the range memory, and skips
// the scan while the table is empty.
// A two-entry queue lets the front accept while the back scans; busy
// rises only when the queue is full. Reset empties the table and depth.
module call_return_trace_classifier_top
   import crtc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [31:0]        req_entry_start,
   input  logic [31:0]        req_entry_size,
   input  logic [31:0]        req_prev_pc,
   input  logic [31:0]        req_next_pc,
   input  logic [31:0]        req_instruction,
   output logic               rsp_valid,
   output logic [2:0]         rsp_event_kind,
   output logic               rsp_from_found,
   output logic [5:0]         rsp_from_index,
   output logic               rsp_to_found,
   output logic [5:0]         rsp_to_index,
   output logic signed [15:0] rsp_depth,
   output logic               rsp_table_full
);

   logic     q_full, q_push, q_pop, q_not_empty;
   work_type q_in, q_out;

   crtc_front u_front (
      .start, .busy,
      .req_mode, .req_entry_start, .req_entry_size,
      .req_prev_pc, .req_next_pc, .req_instruction,
      .q_full, .q_push, .q_data(q_in)
   );

   crtc_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_not_empty), .pop_data(q_out)
   );

   crtc_back u_back (
      .clock, .reset, .q_not_empty, .q_data(q_out), .q_pop,
      .rsp_valid, .rsp_event_kind, .rsp_from_found, .rsp_from_index,
      .rsp_to_found, .rsp_to_index, .rsp_depth, .rsp_table_full
   );

endmodule
